[hdl/assert_macros.svh]
// Assertion macros for the checker file of the fraction reducer.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define FRG_ASSERT(lbl, clk_i, rst_n_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define FRG_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/frgcd_pkg.sv]
// Package for the fraction reducer: default width and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package frgcd_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MOD,
		ST_QTOP,
		ST_QBOT,
		ST_FINISH
	} frgcd_state_t;

endpackage

[hdl/fraction_reduce_gcd_core.sv]
// Fraction reducer top level: sequencer, operand registers and output register.
// Depends on frgcd_pkg and frgcd_div.
//
// Usage: a request on the input channel (in_valid, in_stall, top_value,
// bottom_value) carries a signed fraction. The block returns it in lowest
// terms on the output channel (out_valid, out_stall, reduced_top,
// reduced_bottom): sign on the numerator, denominator non-negative, 0/1 for
// a zero numerator (also for 0/0), and +1/0 or -1/0 for a zero denominator.
// One request is in work at a time; in_stall stays high from acceptance
// until the result moves into the output register.
// Every Euclid remainder step and each of the two final divisions runs on
// the one shared divider; k, the number of remainder steps, is data
// dependent, from 0 up to about 1.44 * VALUE_WIDTH, and a zero numerator
// goes to the output register with no division. The next request can be
// taken in the cycle after the result is registered. The divider works
// out one quotient bit per cycle.
// A finished result waits in the output register while out_stall is high,
// and the next request is accepted and worked on meanwhile.
// Reset (arst_n low) drops any request in work and the pending result.
`timescale 1ns / 1ps

module fraction_reduce_gcd_core #(
	parameter int VALUE_WIDTH = frgcd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] top_value,
	input  logic signed [VALUE_WIDTH-1:0] bottom_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [VALUE_WIDTH-1:0] reduced_top,
	output logic        [VALUE_WIDTH-2:0] reduced_bottom
);

	localparam logic [VALUE_WIDTH-1:0] LIMIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] ONE   = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

	frgcd_pkg::frgcd_state_t state_q, state_d;

	// Working registers
	logic [VALUE_WIDTH-1:0] a_q, b_q;
	logic [VALUE_WIDTH-1:0] top_mag_q, bot_mag_q;
	logic [VALUE_WIDTH-1:0] g_q;
	logic [VALUE_WIDTH-1:0] qn_q, qd_q;
	logic                   neg_q;
	logic                   zero_q;
	logic                   sel_a_q;

	// Output register
	logic                          out_valid_q;
	logic signed [VALUE_WIDTH-1:0] reduced_top_q;
	logic        [VALUE_WIDTH-2:0] reduced_bottom_q;

	// Divider hookup
	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend, div_divisor;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo, div_rem;

	logic                   in_take;
	logic                   out_load;
	logic                   a_gt_b;
	logic [VALUE_WIDTH-1:0] top_mag_in, bot_mag_in;
	logic [VALUE_WIDTH-1:0] qn_sat, qd_sat;

	frgcd_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Accept only while the sequencer is idle
	assign in_stall = (state_q != frgcd_pkg::ST_IDLE);
	assign in_take  = in_valid && !in_stall;

	// Magnitudes of the incoming fraction; the most negative value maps to 2^(W-1)
	assign top_mag_in = top_value[VALUE_WIDTH-1] ? (~$unsigned(top_value) + ONE)
		: $unsigned(top_value);
	assign bot_mag_in = bottom_value[VALUE_WIDTH-1] ? (~$unsigned(bottom_value) + ONE)
		: $unsigned(bottom_value);

	assign a_gt_b = (a_q > b_q);

	// The output register takes a result when empty or being emptied this cycle
	assign out_load = (state_q == frgcd_pkg::ST_FINISH) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frgcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests
	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = a_q;
		div_divisor  = b_q;
		unique case (state_q)
			frgcd_pkg::ST_IDLE: begin
				if (in_take) begin
					state_d = frgcd_pkg::ST_STEP;
				end
			end
			frgcd_pkg::ST_STEP: begin
				if (a_q != '0 && b_q != '0) begin
					// Replace the larger value by its remainder modulo the smaller
					div_start    = 1'b1;
					div_dividend = a_gt_b ? a_q : b_q;
					div_divisor  = a_gt_b ? b_q : a_q;
					state_d      = frgcd_pkg::ST_MOD;
				end else if ((a_q | b_q) == '0 || top_mag_q == '0) begin
					state_d = frgcd_pkg::ST_FINISH;
				end else begin
					div_start    = 1'b1;
					div_dividend = top_mag_q;
					div_divisor  = a_q | b_q;
					state_d      = frgcd_pkg::ST_QTOP;
				end
			end
			frgcd_pkg::ST_MOD: begin
				if (div_done) begin
					state_d = frgcd_pkg::ST_STEP;
				end
			end
			frgcd_pkg::ST_QTOP: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = bot_mag_q;
					div_divisor  = g_q;
					state_d      = frgcd_pkg::ST_QBOT;
				end
			end
			frgcd_pkg::ST_QBOT: begin
				if (div_done) begin
					state_d = frgcd_pkg::ST_FINISH;
				end
			end
			frgcd_pkg::ST_FINISH: begin
				if (out_load) begin
					state_d = frgcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frgcd_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath registers; no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_q       <= top_mag_in;
			b_q       <= bot_mag_in;
			top_mag_q <= top_mag_in;
			bot_mag_q <= bot_mag_in;
			neg_q     <= top_value[VALUE_WIDTH-1] ^ bottom_value[VALUE_WIDTH-1];
		end
		if (state_q == frgcd_pkg::ST_STEP) begin
			sel_a_q <= a_gt_b;
			g_q     <= a_q | b_q;
			zero_q  <= ((a_q | b_q) == '0) || (top_mag_q == '0);
		end
		if (state_q == frgcd_pkg::ST_MOD && div_done) begin
			if (sel_a_q) begin
				a_q <= div_rem;
			end else begin
				b_q <= div_rem;
			end
		end
		if (state_q == frgcd_pkg::ST_QTOP && div_done) begin
			qn_q <= div_quo;
		end
		if (state_q == frgcd_pkg::ST_QBOT && div_done) begin
			qd_q <= div_quo;
		end
	end

	// Saturate magnitudes that do not fit the signed range
	assign qn_sat = (qn_q > LIMIT) ? LIMIT : qn_q;
	assign qd_sat = (qd_q > LIMIT) ? LIMIT : qd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (zero_q) begin
				reduced_top_q    <= '0;
				reduced_bottom_q <= ONE[VALUE_WIDTH-2:0];
			end else begin
				reduced_top_q    <= neg_q ? $signed(~qn_q + ONE) : $signed(qn_sat);
				reduced_bottom_q <= qd_sat[VALUE_WIDTH-2:0];
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign reduced_top    = reduced_top_q;
	assign reduced_bottom = reduced_bottom_q;

endmodule

[hdl/frgcd_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on frgcd_pkg for the default width.
`timescale 1ns / 1ps

module frgcd_div #(
	parameter int VALUE_WIDTH = frgcd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [VALUE_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] dsr_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   trial;
	logic                   qbit;
	logic [VALUE_WIDTH-1:0] rem_next;

	// Trial subtract; no borrow means the quotient bit is one.
	assign shifted  = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign trial    = shifted - {1'b0, dsr_q};
	assign qbit     = ~trial[VALUE_WIDTH];
	assign rem_next = qbit ? trial[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[VALUE_WIDTH-2:0], qbit};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/frgcd_checker.sv]
// Port-level checker for the fraction reducer, bound to the top level.
// Depends on frgcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module frgcd_checker #(
	parameter int VALUE_WIDTH = frgcd_pkg::VALUE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [VALUE_WIDTH-1:0] reduced_top,
	input logic        [VALUE_WIDTH-2:0] reduced_bottom
);

	logic in_fire;
	logic top_is_unit;

	assign in_fire     = in_valid && !in_stall;
	assign top_is_unit = (reduced_top == VALUE_WIDTH'(1))
		|| (reduced_top == {VALUE_WIDTH{1'b1}});

	// A stalled result holds
	`FRG_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(reduced_top) && $stable(reduced_bottom), "stalled result changed")

	// A request keeps the block busy in the next cycle
	`FRG_ASSERT(a_busy_after_req, clk, arst_n, in_fire |=> in_stall, "request accepted without going busy")

	// Zero numerator always comes out as 0/1
	`FRG_ASSERT(a_zero_top, clk, arst_n, out_valid && reduced_top == '0 |-> reduced_bottom == (VALUE_WIDTH-1)'(1), "zero numerator without unit denominator")

	// Zero denominator only with a unit numerator
	`FRG_ASSERT(a_zero_bottom, clk, arst_n, out_valid && reduced_bottom == '0 |-> top_is_unit, "zero denominator with non-unit numerator")

	// No result is offered during reset
	`FRG_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "result offered in reset")

endmodule

bind fraction_reduce_gcd_core frgcd_checker #(
	.VALUE_WIDTH(VALUE_WIDTH)
) u_frgcd_checker (.*);

[sim/fraction_reduce_gcd_core_tb.sv]
// Self-checking testbench for fraction_reduce_gcd_core: random idle and stall on both sides.
// Predicts every reduced fraction with an independent Euclid routine in a scoreboard class.
// Depends on frgcd_pkg and fraction_reduce_gcd_core.
`timescale 1ns / 1ps

localparam int FRAC_W = frgcd_pkg::VALUE_WIDTH_DEF;

typedef logic signed [FRAC_W-1:0] value_t;
typedef logic        [FRAC_W-2:0] bottom_t;

typedef struct packed {
	value_t  top;
	bottom_t bottom;
} fraction_t;

class fraction_scoreboard;
	fraction_t pending_fractions[$];
	int        mismatch_count;

	function new();
		mismatch_count = 0;
	endfunction

	// Reduce to lowest terms: sign on top, 0/1 for a zero top, +-1/0 for a zero bottom.
	function fraction_t reduce_fraction(value_t top, value_t bottom);
		longint unsigned top_mag, bottom_mag, a, b, divisor, qn, qd, limit;
		fraction_t       r;
		top_mag    = top[FRAC_W-1] ? -longint'(top) : longint'(top);
		bottom_mag = bottom[FRAC_W-1] ? -longint'(bottom) : longint'(bottom);
		limit      = (64'd1 << (FRAC_W - 1)) - 1;
		a = top_mag;
		b = bottom_mag;
		while (a != 0 && b != 0) begin
			if (a > b) begin
				a = a % b;
			end else begin
				b = b % a;
			end
		end
		divisor = a + b;
		if (divisor == 0 || top_mag == 0) begin
			r.top    = '0;
			r.bottom = bottom_t'(1);
			return r;
		end
		qn = top_mag / divisor;
		qd = bottom_mag / divisor;
		if (qd > limit) begin
			qd = limit;
		end
		if (top[FRAC_W-1] != bottom[FRAC_W-1]) begin
			r.top = value_t'(-qn);
		end else begin
			r.top = value_t'((qn > limit) ? limit : qn);
		end
		r.bottom = bottom_t'(qd);
		return r;
	endfunction

	function void note_request(value_t top, value_t bottom);
		pending_fractions.push_back(reduce_fraction(top, bottom));
	endfunction

	function int count_pending();
		return pending_fractions.size();
	endfunction

	function void check_result(value_t top, bottom_t bottom);
		fraction_t want;
		if (pending_fractions.size() == 0) begin
			$error("result with no pending request: reduced_top %0d, reduced_bottom %0d",
				top, bottom);
			mismatch_count++;
			return;
		end
		want = pending_fractions.pop_front();
		if (top !== want.top) begin
			$error("reduced_top mismatch: expected %0d, actual %0d", $signed(want.top), top);
			mismatch_count++;
		end
		if (bottom !== want.bottom) begin
			$error("reduced_bottom mismatch: expected %0d, actual %0d", want.bottom, bottom);
			mismatch_count++;
		end
	endfunction
endclass

module fraction_reduce_gcd_core_tb;

	localparam longint unsigned MAG_MAX = (64'd1 << (FRAC_W - 1)) - 1;
	localparam value_t VALUE_MAX = value_t'(MAG_MAX);
	localparam value_t MOST_NEG = {1'b1, {(FRAC_W-1){1'b0}}};
	localparam int RANDOM_REQUESTS = 1080;
	// Worst item takes about 48 divider passes; wait longer than that after drain.
	localparam int DRAIN_CYCLES = 2000;
	// Allow several times the length of the slowest run.
	localparam int CYCLE_LIMIT = 10_000_000;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	value_t  top_value;
	value_t  bottom_value;
	logic    out_valid;
	logic    out_stall;
	value_t  reduced_top;
	bottom_t reduced_bottom;

	fraction_scoreboard sb = new();
	// While set, neither side inserts idle cycles.
	bit steady_phase;
	int cycle_count;

	fraction_reduce_gcd_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.top_value     (top_value),
		.bottom_value  (bottom_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.reduced_top   (reduced_top),
		.reduced_bottom(reduced_bottom)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned idle_cycles();
		return steady_phase ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic value_t signed_value(longint unsigned mag);
		return $urandom_range(0, 1) ? value_t'(-mag) : value_t'(mag);
	endfunction

	// Draw over the whole field, but keep off the most negative value.
	function automatic value_t any_value();
		value_t v;
		v = value_t'($urandom);
		return (v == MOST_NEG) ? ~v : v;
	endfunction

	function automatic value_t extreme_value();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return value_t'(1);
			2: return value_t'(-1);
			3: return VALUE_MAX;
			default: return -VALUE_MAX;
		endcase
	endfunction

	// About two fifths are fractions with a shared factor, so the reduction does real work.
	task automatic make_random_fraction(output value_t top, output value_t bottom);
		int unsigned     kind;
		longint unsigned bound;
		longint unsigned factor;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			factor = $urandom_range(1, 1 << $urandom_range(0, 16));
			bound  = MAG_MAX / factor;
			if ($urandom_range(0, 1) && bound > 1000) begin
				bound = 1000;
			end
			top    = signed_value(factor * $urandom_range(0, int'(bound)));
			bottom = signed_value(factor * $urandom_range(0, int'(bound)));
		end else if (kind < 65) begin
			top    = signed_value($urandom_range(0, 1000));
			bottom = signed_value($urandom_range(0, 1000));
		end else if (kind < 85) begin
			top    = any_value();
			bottom = any_value();
		end else if (kind < 95) begin
			case ($urandom_range(0, 2))
				0: begin
					top    = '0;
					bottom = any_value();
				end
				1: begin
					top    = any_value();
					bottom = '0;
				end
				default: begin
					top    = signed_value($urandom_range(0, 20));
					bottom = '0;
				end
			endcase
		end else begin
			top    = extreme_value();
			bottom = extreme_value();
		end
	endtask

	// Present one request after a random gap; hold it until the block takes it.
	task automatic send_request(value_t top, value_t bottom);
		int unsigned gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		top_value    <= top;
		bottom_value <= bottom;
		do @(posedge clk); while (in_stall);
		sb.note_request(top, bottom);
	endtask

	// Drop valid and hold off until every expected result has been checked.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.count_pending() != 0);
	endtask

	// Result side: stall a random number of cycles, then take the next result.
	initial begin
		int unsigned stall_cycles;
		out_stall <= 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall_cycles = idle_cycles();
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(reduced_top, reduced_bottom);
		end
	end

	// Stop a hung run.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		value_t t;
		value_t b;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		top_value    <= '0;
		bottom_value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero numerator, with and without a zero denominator.
		send_request('0, '0);
		send_request('0, 5);
		send_request('0, -7);
		send_request('0, VALUE_MAX);
		// Zero denominator gives a signed unit over zero.
		send_request(5, '0);
		send_request(-5, '0);
		send_request(VALUE_MAX, '0);
		// Every sign combination.
		send_request(1, 1);
		send_request(-1, 1);
		send_request(1, -1);
		send_request(-1, -1);
		send_request(6, 4);
		send_request(-6, 4);
		send_request(6, -4);
		send_request(-6, -4);
		// Field extremes.
		send_request(VALUE_MAX, VALUE_MAX);
		send_request(-VALUE_MAX, -VALUE_MAX);
		send_request(VALUE_MAX, -VALUE_MAX);
		send_request(VALUE_MAX, 1);
		send_request(-VALUE_MAX, 1);
		send_request(1, VALUE_MAX);
		send_request(1, -VALUE_MAX);
		// Consecutive Fibonacci numbers take the longest Euclid chain.
		send_request(1836311903, 1134903170);
		send_request(32'sh4000_0000, 32'sh0010_0000);
		send_request(-2147483646, 2);
		wait_for_results();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady_phase = (i % 160) >= 120;
			if (i % 360 == 359) begin
				wait_for_results();
			end
			make_random_fraction(t, b);
			send_request(t, b);
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/frgcd_pkg.sv
hdl/frgcd_div.sv
hdl/fraction_reduce_gcd_core.sv
hdl/frgcd_checker.sv
sim/fraction_reduce_gcd_core_tb.sv
